// ===== rtl/tpa_pkg.sv =====
// Package for the tile pool allocator: widths, command and status codes.
// No dependencies.
`default_nettype none
package tpa_pkg;
    localparam int NumTilesDefault   = 1024;
    localparam int TileTokensDefault = 64;
    localparam int EvictMargin       = 10;
    localparam int CmdW  = 2;
    localparam int StatW = 2;
    localparam int PosW  = 20;
    localparam int WinW  = 11;
    localparam int StampW = 32;
    localparam logic [WinW-1:0] WinReset = 11'd128;
    localparam logic [StampW-1:0] FrameMax = 32'h7FFF_FFFF;

    localparam logic [CmdW-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CmdW-1:0] CMD_FREE  = 2'd1;
    localparam logic [CmdW-1:0] CMD_PLAN  = 2'd2;

    localparam logic [StatW-1:0] ST_DONE    = 2'd0;
    localparam logic [StatW-1:0] ST_EMPTY   = 2'd1;
    localparam logic [StatW-1:0] ST_IGNORED = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/tile_pool_allocator_with_age_eviction_core.sv =====
// Tile pool allocator with age eviction: top level with the command sequencer.
// Depends on tpa_pkg, tpa_stack, tpa_marks.
//
// Usage: requests enter on s_* (valid/ready); one result per request leaves on
// m_* (valid/ready). window_tile_count is to be written on cfg_* only while idle;
// the block itself does not enforce it. One request is in work at a time. From the
// accepting edge, allocate reads the stack and writes the marks before its result
// is valid (an allocate on an empty pool goes straight to the result), free reads
// the marks, then checks and pushes, and plan frame walks every tile through the
// marks memory with a read and a write-back per tile, set by the single marks port pair.
// The result sits in an output register; the next request is taken only
// after the result has been taken, so a stalled receiver holds the block.
// After reset a clearing pass over all NUM_TILES entries writes both memories
// (stack entry i = i, marks = not resident, no owner, stamp -1); s_ready
// stays low during it. Configuration writes are taken at any time.
`default_nettype none
module tile_pool_allocator_with_age_eviction_core #(
    parameter int NumTiles   = tpa_pkg::NumTilesDefault,
    parameter int TileTokens = tpa_pkg::TileTokensDefault
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [tpa_pkg::CmdW-1:0]    s_command,
    input  wire logic [5:0]                  s_owner_layer,
    input  wire logic [3:0]                  s_owner_head,
    input  wire logic [9:0]                  s_tile_to_free,
    input  wire logic [tpa_pkg::PosW-1:0]    s_token_position,
    input  wire logic [tpa_pkg::PosW-1:0]    s_window_tokens,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [tpa_pkg::StatW-1:0]        m_status,
    output logic [9:0]                       m_granted_tile,
    output logic [10:0]                      m_evicted_count,
    output logic [10:0]                      m_free_tiles,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [tpa_pkg::WinW-1:0]    cfg_data
);
    import tpa_pkg::*;

    localparam int IdxW  = (NumTiles > 1) ? $clog2(NumTiles) : 1;
    localparam int CntW  = $clog2(NumTiles + 1);
    localparam int OwnW  = 10;
    localparam int DataW = 1 + OwnW + StampW;
    localparam int WideW = 40;
    localparam logic [CntW-1:0] NumTilesC = CntW'(NumTiles);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_AL_RD = 4'd2;
    localparam logic [3:0] S_FR_RD = 4'd3;
    localparam logic [3:0] S_FR_CK = 4'd4;
    localparam logic [3:0] S_PL_RD = 4'd5;
    localparam logic [3:0] S_PL_WR = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;

    logic [3:0]       state_reg, state_next;
    logic [CntW-1:0]  scan_reg, scan_next;
    logic [CntW-1:0]  depth_reg, depth_next;
    logic [StampW-1:0] frame_reg, frame_next;
    logic [WinW-1:0]  win_reg;
    logic [OwnW-1:0]  own_reg;
    logic [9:0]       victim_reg;
    logic [WideW-1:0] start_reg, end_reg;
    logic [WideW-1:0] thr_reg;
    logic [10:0]      evict_reg, evict_next;
    logic             m_valid_reg;
    logic [StatW-1:0] status_reg;
    logic [9:0]       grant_reg;

    logic             st_we, mk_we;
    logic [IdxW-1:0]  st_waddr, st_wdata, st_raddr, st_rdata;
    logic [IdxW-1:0]  mk_waddr, mk_raddr;
    logic [DataW-1:0] mk_wdata, mk_rdata;

    tpa_stack #(.NumTiles(NumTiles), .IdxW(IdxW)) u_stack (
        .aclk(aclk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rdata)
    );
    tpa_marks #(.NumTiles(NumTiles), .IdxW(IdxW), .DataW(DataW)) u_marks (
        .aclk(aclk), .we(mk_we), .waddr(mk_waddr), .wdata(mk_wdata),
        .raddr(mk_raddr), .rdata(mk_rdata)
    );

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= WinReset;
        end else if (cfg_valid) begin
            win_reg <= cfg_data;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_status = status_reg;
    assign m_granted_tile = grant_reg;
    assign m_evicted_count = evict_reg;
    assign m_free_tiles = 11'(depth_reg);

    // marks fields
    logic             rd_res;
    logic [StampW-1:0] rd_stamp;
    logic [WideW-1:0] tidx_w, rd_stamp_w, frame_w;
    logic             in_win, aged, outside, evict_now;
    assign rd_res   = mk_rdata[DataW-1];
    assign rd_stamp = mk_rdata[StampW-1:0];
    assign tidx_w   = WideW'(scan_reg);
    assign frame_w  = WideW'(frame_reg);
    assign rd_stamp_w = {{(WideW-StampW){rd_stamp[StampW-1]}}, rd_stamp};
    assign in_win   = (tidx_w >= start_reg) && (tidx_w <= end_reg);
    // stamp used in the age test is the one after window stamping
    assign aged = $signed(in_win ? frame_w : rd_stamp_w) < $signed(thr_reg);
    assign outside = ($signed(tidx_w) + 40'sd10 < $signed(start_reg))
                  || ($signed(tidx_w) > $signed(end_reg) + 40'sd10);
    assign evict_now = rd_res && aged && outside;

    logic [PosW-1:0] diff;
    assign diff = s_token_position - s_window_tokens;

    always_comb begin
        state_next = state_reg;
        scan_next  = scan_reg;
        depth_next = depth_reg;
        frame_next = frame_reg;
        evict_next = evict_reg;
        st_we = 1'b0; st_waddr = '0; st_wdata = '0;
        st_raddr = IdxW'(depth_reg - CntW'(1));
        mk_we = 1'b0; mk_waddr = '0; mk_wdata = '0;
        mk_raddr = IdxW'(scan_reg);
        case (state_reg)
            S_CLR: begin
                st_we = 1'b1; st_waddr = IdxW'(scan_reg); st_wdata = IdxW'(scan_reg);
                mk_we = 1'b1; mk_waddr = IdxW'(scan_reg);
                mk_wdata = {1'b0, {OwnW{1'b1}}, {StampW{1'b1}}};
                scan_next = scan_reg + CntW'(1);
                if (scan_reg == NumTilesC - CntW'(1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    evict_next = '0;
                    scan_next = '0;
                    if (s_command == CMD_ALLOC) begin
                        state_next = (depth_reg == '0) ? S_OUT : S_AL_RD;
                    end else if (s_command == CMD_FREE) begin
                        state_next = S_FR_RD;
                    end else if (s_command == CMD_PLAN) begin
                        if (frame_reg < FrameMax) begin
                            frame_next = frame_reg + 32'd1;
                        end
                        state_next = S_PL_RD;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_AL_RD: begin
                // stack data valid now
                mk_we = 1'b1; mk_waddr = st_rdata;
                mk_wdata = {1'b1, own_reg, frame_reg};
                depth_next = depth_reg - CntW'(1);
                state_next = S_OUT;
            end
            S_FR_RD: begin
                mk_raddr = IdxW'(victim_reg);
                state_next = S_FR_CK;
            end
            S_FR_CK: begin
                if (rd_res && (CntW'(victim_reg) < NumTilesC)) begin
                    mk_we = 1'b1; mk_waddr = IdxW'(victim_reg);
                    mk_wdata = {1'b0, {OwnW{1'b1}}, rd_stamp};
                    st_we = 1'b1; st_waddr = IdxW'(depth_reg);
                    st_wdata = IdxW'(victim_reg);
                    depth_next = depth_reg + CntW'(1);
                end
                state_next = S_OUT;
            end
            S_PL_RD: begin
                state_next = S_PL_WR;
            end
            S_PL_WR: begin
                mk_we = 1'b1; mk_waddr = IdxW'(scan_reg);
                mk_wdata = {rd_res, mk_rdata[DataW-2:StampW],
                            in_win ? frame_reg : rd_stamp};
                if (evict_now) begin
                    mk_wdata = {1'b0, {OwnW{1'b1}}, in_win ? frame_reg : rd_stamp};
                    st_we = 1'b1; st_waddr = IdxW'(depth_reg);
                    st_wdata = IdxW'(scan_reg);
                    depth_next = depth_reg + CntW'(1);
                    evict_next = evict_reg + 11'd1;
                end
                scan_next = scan_reg + CntW'(1);
                mk_raddr = IdxW'(scan_reg + CntW'(1));
                state_next = (scan_reg == NumTilesC - CntW'(1)) ? S_OUT : S_PL_RD;
            end
            S_OUT: begin
                if (m_valid_reg && m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            scan_reg    <= '0;
            depth_reg   <= NumTilesC;
            frame_reg   <= '0;
            evict_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            depth_reg <= depth_next;
            frame_reg <= frame_next;
            evict_reg <= evict_next;
            if (state_reg == S_OUT && m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end else if (state_reg != S_OUT && state_next == S_OUT) begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_valid) begin
            own_reg    <= {s_owner_layer, s_owner_head};
            victim_reg <= s_tile_to_free;
            start_reg  <= (s_token_position >= s_window_tokens)
                        ? WideW'(diff / TileTokens) : '0;
            end_reg    <= WideW'(s_token_position / TileTokens);
            thr_reg    <= WideW'({1'b0, frame_next}) - (WideW'(win_reg) << 1);
            status_reg <= ST_DONE;
            grant_reg  <= '0;
            if (s_command == CMD_ALLOC && depth_reg == '0) begin
                status_reg <= ST_EMPTY;
            end
        end
        if (state_reg == S_AL_RD) begin
            grant_reg <= 10'(st_rdata);
        end
        if (state_reg == S_FR_CK && !(rd_res && (CntW'(victim_reg) < NumTilesC))) begin
            status_reg <= ST_IGNORED;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/tpa_stack.sv =====
// Free list stack memory for the tile pool allocator.
// No dependencies. Cleared to entry i = i by the controller's sweep.
`default_nettype none
module tpa_stack #(
    parameter int NumTiles = 1024,
    parameter int IdxW = 10
) (
    input  wire logic            aclk,
    input  wire logic            we,
    input  wire logic [IdxW-1:0] waddr,
    input  wire logic [IdxW-1:0] wdata,
    input  wire logic [IdxW-1:0] raddr,
    output logic      [IdxW-1:0] rdata
);
    logic [IdxW-1:0] mem [NumTiles];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/tpa_marks.sv =====
// Per-tile marks memory: resident bit, owner record and last stamp.
// No dependencies. One write port, one registered read port.
`default_nettype none
module tpa_marks #(
    parameter int NumTiles = 1024,
    parameter int IdxW = 10,
    parameter int DataW = 43
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [IdxW-1:0]  waddr,
    input  wire logic [DataW-1:0] wdata,
    input  wire logic [IdxW-1:0]  raddr,
    output logic      [DataW-1:0] rdata
);
    logic [DataW-1:0] mem [NumTiles];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/tpa_checker.sv =====
// Port-level checker for the tile pool allocator, bound to the top level.
// Depends on tpa_pkg.
`default_nettype none
module tpa_checker (
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_valid,
    input wire logic                      s_ready,
    input wire logic                      m_valid,
    input wire logic                      m_ready,
    input wire logic [tpa_pkg::StatW-1:0] m_status,
    input wire logic [9:0]                m_granted_tile,
    input wire logic [10:0]               m_free_tiles
);
    import tpa_pkg::*;
    a_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result changed while stalled");
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("request taken while result pending");
    a_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_DONE |-> m_granted_tile == 10'd0)
        else $error("grant on failed request");
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> $stable(m_free_tiles))
        else $error("depth changed on accept");
endmodule
bind tile_pool_allocator_with_age_eviction_core tpa_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
    .m_granted_tile(m_granted_tile), .m_free_tiles(m_free_tiles)
);
`default_nettype wire
